// ===== src/ccs_pkg.sv =====
// Package: shared types and constants for the contour cell segmenter.
`timescale 1ns / 1ps
package ccs_pkg;

	localparam int MAX_LEVELS_DEF = 16;
	localparam int PEN_COUNT_DEF  = 6;
	localparam int RESULT_LIMIT   = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int PADDR_W        = 3;

	// Register addresses.
	localparam logic [PADDR_W-1:0] ADDR_INV_INTERVAL = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_BLOCK_PIXELS = 3'd4;

	localparam logic [23:0] INV_INTERVAL_RST = 24'd65536;
	localparam logic [7:0]  BLOCK_PIXELS_RST = 8'd8;

	// Clamped samples: level units with 24 fraction bits, 14 integer bits plus sign.
	localparam int SW = 39;
	localparam logic signed [SW-1:0] S_LO = -(39'sd300 <<< 24);
	localparam logic signed [SW-1:0] S_HI = (39'sd10000 <<< 24);

	// Division widths: numerator bp*n below 2^8 * 2^38.
	localparam int NW = 46;
	localparam int DW = 38;

	typedef struct packed {
		logic signed [23:0] h_top_left;
		logic signed [23:0] h_top_right;
		logic signed [23:0] h_bottom_right;
		logic signed [23:0] h_bottom_left;
		logic [15:0]        cell_x;
		logic [15:0]        cell_y;
	} in_item_t;

	typedef struct packed {
		logic [16:0] x_start;
		logic [16:0] y_start;
		logic [16:0] x_end;
		logic [16:0] y_end;
		logic [2:0]  pen_index;
		logic        level_overflow;
		logic        last;
	} out_item_t;

	// Classified cell handed from the front to the back.
	typedef struct packed {
		logic signed [3:0][SW-1:0] s;
		logic signed [3:0][14:0]   lv;
		logic signed [14:0]        k_first;
		logic signed [14:0]        k_last;
		logic                      ovf;
		logic [15:0]               cx;
		logic [15:0]               cy;
	} cell_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage

// ===== src/ccs_front.sv =====
// Front end: scales, clamps and floors the corner heights and finds the level range.
`timescale 1ns / 1ps
module ccs_front #(
	parameter int MAX_LEVELS = ccs_pkg::MAX_LEVELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ccs_pkg::in_item_t in_data,
	input  logic [23:0]       inv_interval,
	output logic              cell_valid,
	input  logic              cell_ready,
	output ccs_pkg::cell_t    cell_data
);
	import ccs_pkg::*;

	logic                      busy_s1;
	logic [1:0]                cnt_q;
	logic signed [3:0][23:0]   h_s1;
	logic [15:0]               cx_s1, cy_s1;
	logic signed [3:0][SW-1:0] s_q;
	logic signed [3:0][14:0]   lv_q;
	logic                      done_q;
	logic signed [47:0]        prod;
	logic signed [SW-1:0]      clamped;
	logic signed [14:0]        lv_c;
	logic signed [14:0]        lo, hi;
	logic signed [15:0]        span;

	assign in_ready = !busy_s1;

	// One shared multiplier scales one corner per cycle.
	assign prod = $signed(h_s1[cnt_q]) * $signed({1'b0, inv_interval});

	always_comb begin
		if (prod < 48'(S_LO))
			clamped = S_LO;
		else if (prod > 48'(S_HI))
			clamped = S_HI;
		else
			clamped = prod[SW-1:0];
		lv_c = clamped[SW-1:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else if (!busy_s1) begin
			if (in_valid) begin
				busy_s1 <= 1'b1;
				cnt_q   <= '0;
				done_q  <= 1'b0;
			end
		end else if (!done_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3)
				done_q <= 1'b1;
		end else if (cell_ready) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_s1 && in_valid) begin
			h_s1[0] <= in_data.h_top_left;
			h_s1[1] <= in_data.h_top_right;
			h_s1[2] <= in_data.h_bottom_right;
			h_s1[3] <= in_data.h_bottom_left;
			cx_s1   <= in_data.cell_x;
			cy_s1   <= in_data.cell_y;
		end
		if (busy_s1 && !done_q) begin
			s_q[cnt_q]  <= clamped;
			lv_q[cnt_q] <= lv_c;
		end
	end

	// Minimum and maximum of the four floored levels.
	always_comb begin
		lo = lv_q[0];
		hi = lv_q[0];
		for (int i = 1; i < 4; i++) begin
			if ($signed(lv_q[i]) < lo) lo = lv_q[i];
			if ($signed(lv_q[i]) > hi) hi = lv_q[i];
		end
		span = 16'(hi) - 16'(lo);
	end

	assign cell_valid        = busy_s1 && done_q;
	assign cell_data.s       = s_q;
	assign cell_data.lv      = lv_q;
	assign cell_data.ovf     = span > 16'(MAX_LEVELS);
	assign cell_data.k_first = lo + 15'sd1;
	assign cell_data.k_last  = (span > 16'(MAX_LEVELS)) ? 15'(lo + 15'(MAX_LEVELS)) : hi;
	assign cell_data.cx      = cx_s1;
	assign cell_data.cy      = cy_s1;

endmodule

// ===== src/ccs_queue.sv =====
// Small queue between the front and the back end.
`timescale 1ns / 1ps
module ccs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ccs_pkg::cell_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output ccs_pkg::cell_t rd_data
);
	import ccs_pkg::*;

	cell_t       mem_q [QUEUE_DEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign wr_ready = cnt_q != 2'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count did not grow");
`endif

endmodule

// ===== src/ccs_back.sv =====
// Back end: walks the levels, interpolates crossings with a serial divider, emits segments.
`timescale 1ns / 1ps
module ccs_back #(
	parameter int PEN_COUNT = ccs_pkg::PEN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cell_valid,
	output logic               cell_ready,
	input  ccs_pkg::cell_t     cell_data,
	input  logic [7:0]         block_pixels,
	output logic               out_valid,
	input  logic               out_ready,
	output ccs_pkg::out_item_t out_data
);
	import ccs_pkg::*;

	// Offset that lifts the lowest level above zero, a multiple of the pen count.
	localparam int PEN_OFS = ((300 + PEN_COUNT - 1) / PEN_COUNT) * PEN_COUNT;
	localparam int PEN_SH  = 24;
	localparam logic [24:0] PEN_RCP = 25'(((1 << PEN_SH) + PEN_COUNT - 1) / PEN_COUNT);

	back_state_t              state_q, state_d;
	cell_t                    cell_q;
	logic signed [14:0]       k_q;
	logic [3:0]               pen_q;
	logic [3:0]               hit_q;
	logic [1:0]               edge_q;
	logic [5:0]               bit_q;
	logic [NW-1:0]            quo_q;
	logic [DW:0]              rem_q;
	logic [DW-1:0]            den_q;
	logic [3:0][NW-1:0]       off_q;
	logic [5:0]               cnt_q;
	logic [1:0]               seg_q;
	logic [NW-1:0]            num_s;
	logic [DW-1:0]            den_s;
	logic [3:0]               hit_c;
	logic [DW:0]              rem_sh;
	logic                     ge;
	logic                     emit_ok;
	logic [1:0]               seg_n;
	logic [1:0]               st_e, en_e;
	logic [2:0]               m1;
	logic [1:0]               a_e;
	logic signed [SW+1:0]     kq, nn, dd;
	logic                     more_seg;
	logic [16:0]              px [4];
	logic [16:0]              py [4];
	logic [16:0]              bp17;
	logic                     last_lvl;
	logic                     div_done;
	logic [14:0]              pen_u;
	logic [39:0]              pen_prod;
	logic [14:0]              pen_quo;
	logic [14:0]              pen_rem;

	// Edge crossings for the current level.
	always_comb begin
		for (int e = 0; e < 4; e++)
			hit_c[e] = ($signed(cell_q.lv[(e + 3) & 3]) < k_q) !=
				($signed(cell_q.lv[e]) < k_q);
	end

	// Numerator and denominator for the edge being divided.
	always_comb begin
		a_e = edge_q + 2'd3;
		kq  = $signed({k_q, 24'd0});
		dd  = (SW+2)'($signed(cell_q.s[edge_q])) - (SW+2)'($signed(cell_q.s[a_e]));
		if (edge_q == 2'd1 || edge_q == 2'd2)
			nn = kq - (SW+2)'($signed(cell_q.s[a_e]));
		else
			nn = (SW+2)'($signed(cell_q.s[edge_q])) - kq;
		if (dd < 0) begin
			nn = -nn;
			dd = -dd;
		end
		if (nn < 0) nn = '0;
		num_s = NW'(block_pixels) * NW'(nn[DW-1:0]);
		den_s = dd[DW-1:0];
	end

	// Pen of the first level by reciprocal multiplication of the offset level.
	always_comb begin
		pen_u    = 15'(cell_data.k_first + 15'(PEN_OFS));
		pen_prod = 40'(pen_u) * 40'(PEN_RCP);
		pen_quo  = pen_prod[PEN_SH +: 15];
		pen_rem  = pen_u - 15'(pen_quo * 15'(PEN_COUNT));
	end

	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// The last edge is finished either by a skip at load or by its final divider step.
	assign div_done = (edge_q == 2'd3) &&
		((bit_q == 6'(NW) && (!hit_q[3] || den_s == '0)) || bit_q == 6'(NW - 1));

	// Pairing: current segment starts at seg_q, ends at the next crossed edge (edges 2 and 3 swapped).
	always_comb begin
		m1 = 3'd4;
		for (int j = 3; j >= 1; j--)
			if (j > seg_q && hit_q[j]) m1 = 3'(j);
		st_e = seg_q;
		en_e = m1[1:0];
		if (seg_q == 2'd2 && m1 == 3'd3) begin
			st_e = 2'd3;
			en_e = 2'd2;
		end
		seg_n = 2'd0;
		more_seg = 1'b0;
		for (int j = 3; j >= 0; j--)
			if (j > m1 && hit_q[j]) begin
				seg_n = 2'(j);
				more_seg = 1'b1;
			end
	end

	// Crossing points in pixels.
	assign bp17 = 17'(block_pixels);
	always_comb begin
		for (int e = 0; e < 4; e++) begin
			if (e[0]) begin
				px[e] = 17'(cell_q.cx) + off_q[e][16:0];
				py[e] = 17'(cell_q.cy) + ((e == 3) ? bp17 : 17'd0);
			end else begin
				px[e] = 17'(cell_q.cx) + ((e == 2) ? bp17 : 17'd0);
				py[e] = 17'(cell_q.cy) + off_q[e][16:0];
			end
		end
	end

	assign last_lvl = k_q >= cell_q.k_last;
	assign emit_ok  = cnt_q < 6'(RESULT_LIMIT);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (cell_valid) state_d = ST_LEVEL;
			ST_LEVEL: begin
				if (k_q > cell_q.k_last)
					state_d = ST_IDLE;
				else if (hit_c != 4'd0)
					state_d = ST_DIV;
			end
			ST_DIV:   if (div_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!emit_ok || out_ready) begin
					if (!more_seg)
						state_d = last_lvl ? ST_IDLE : ST_LEVEL;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cell_ready = state_q == ST_IDLE;
		out_valid  = (state_q == ST_EMIT) && emit_ok;
		out_data.x_start        = px[st_e];
		out_data.y_start        = py[st_e];
		out_data.x_end          = px[en_e];
		out_data.y_end          = py[en_e];
		out_data.pen_index      = 3'(pen_q);
		out_data.level_overflow = cell_q.ovf;
		out_data.last = (last_lvl && !more_seg) || (cnt_q == 6'(RESULT_LIMIT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cell_valid) begin
					cell_q <= cell_data;
					k_q    <= cell_data.k_first;
					cnt_q  <= '0;
					// Nonnegative k mod PEN_COUNT; k stays within -299..10001.
					pen_q  <= pen_rem[3:0];
				end
			end
			ST_LEVEL: begin
				hit_q  <= hit_c;
				edge_q <= 2'd0;
				bit_q  <= 6'(NW);
				if (hit_c == 4'd0 && k_q <= cell_q.k_last) begin
					k_q   <= k_q + 15'sd1;
					pen_q <= (pen_q == 4'(PEN_COUNT - 1)) ? 4'd0 : pen_q + 4'd1;
				end
				seg_q <= hit_c[0] ? 2'd0 : hit_c[1] ? 2'd1 : hit_c[2] ? 2'd2 : 2'd3;
			end
			ST_DIV: begin
				if (bit_q == 6'(NW)) begin
					// Load the divider for this edge.
					quo_q <= num_s;
					rem_q <= '0;
					den_q <= den_s;
					bit_q <= '0;
					if (!hit_q[edge_q] || den_s == '0) begin
						off_q[edge_q] <= '0;
						bit_q  <= 6'(NW);
						edge_q <= edge_q + 2'd1;
					end
				end else begin
					rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
					quo_q <= {quo_q[NW-2:0], ge};
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'(NW - 1)) begin
						off_q[edge_q] <= {quo_q[NW-2:0], ge};
						bit_q  <= 6'(NW);
						edge_q <= edge_q + 2'd1;
					end
				end
			end
			ST_EMIT: begin
				if (!emit_ok || out_ready) begin
					if (emit_ok) cnt_q <= cnt_q + 6'd1;
					seg_q <= seg_n;
					if (!more_seg) begin
						k_q   <= k_q + 15'sd1;
						pen_q <= (pen_q == 4'(PEN_COUNT - 1)) ? 4'd0 : pen_q + 4'd1;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("result outside emit");
	a_pen_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pen_index < 3'(PEN_COUNT)) else $error("pen out of range");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(RESULT_LIMIT)) else $error("result count overrun");
`endif

endmodule

// ===== src/contour_cell_segmenter.sv =====
// Top level: contour segment generator for one grid cell per transfer.
//
// Usage: each input transfer carries the four corner heights (signed Q16.8) and the
// cell's pixel origin. The block answers with zero to 32 output transfers, one per
// contour line segment; last marks the final segment of a cell, and a flat cell
// gives no output at all. Registers inv_interval (address 0) and block_pixels
// (address 4) must be written over the APB port only while the block is idle; the
// block itself does not enforce this. The front scales the four corners one after
// another through one shared multiplier and hands the cell on; it takes no new cell
// until that cell has been handed on. The back walks the levels one by one, runs the
// bit-serial divider for each crossed edge, skips edges without a crossing, and emits
// one segment at a time. The serial divider sets throughput. A two-entry queue lets
// the front take the next cell meanwhile.
// Reset clears all control state and loads the register defaults; when the receiver
// stalls, the current segment is held unchanged until it is transferred.
`timescale 1ns / 1ps
module contour_cell_segmenter #(
	parameter int MAX_LEVELS = ccs_pkg::MAX_LEVELS_DEF,
	parameter int PEN_COUNT  = ccs_pkg::PEN_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ccs_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ccs_pkg::out_item_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ccs_pkg::*;

	logic [23:0] inv_interval_q;
	logic [7:0]  block_pixels_q;
	logic        fc_valid, fc_ready, qb_valid, qb_ready;
	cell_t       fc_data, qb_data;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_interval_q <= INV_INTERVAL_RST;
			block_pixels_q <= BLOCK_PIXELS_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_INV_INTERVAL) inv_interval_q <= pwdata[23:0];
			if (paddr == ADDR_BLOCK_PIXELS) block_pixels_q <= pwdata[7:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_INV_INTERVAL: prdata = {8'd0, inv_interval_q};
			ADDR_BLOCK_PIXELS: prdata = {24'd0, block_pixels_q};
			default:           prdata = '0;
		endcase
	end

	ccs_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.inv_interval(inv_interval_q),
		.cell_valid(fc_valid), .cell_ready(fc_ready), .cell_data(fc_data)
	);

	ccs_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fc_valid), .wr_ready(fc_ready), .wr_data(fc_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
	);

	ccs_back #(.PEN_COUNT(PEN_COUNT)) u_back (
		.clk, .arst_n,
		.cell_valid(qb_valid), .cell_ready(qb_ready), .cell_data(qb_data),
		.block_pixels(block_pixels_q),
		.out_valid, .out_ready, .out_data
	);

endmodule

// ===== dv/tb_contour_cell_segmenter.sv =====
// Self-checking testbench for the contour cell segmenter: directed cells, then random cells.
`timescale 1ns / 1ps
module tb_contour_cell_segmenter;
	import ccs_pkg::*;

	localparam longint FRAC_ONE   = 64'sd16777216;
	localparam longint LEVEL_LO   = -300;
	localparam longint LEVEL_HI   = 10000;
	localparam int     MAX_LVL    = 16;
	localparam int     PENS       = 6;
	localparam int     IDLE_WAIT  = 4000;
	localparam longint CYCLE_MAX  = 64'd6000000;
	localparam int     PHASE_ITEMS = 80;

	// Directed row kinds: checked by the predictor, no result expected, or a result typed in by hand.
	typedef enum int {ROW_PREDICT, ROW_NONE, ROW_ONE} row_kind_t;

	typedef struct {
		logic [23:0] inv;
		logic [7:0]  bp;
		in_item_t    grid_item;
		row_kind_t   kind;
		out_item_t   seg;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [23:0] cfg_inv;
	logic [7:0]  cfg_bp;
	out_item_t   seg_expect_q[$];
	dir_row_t    dir_rows[$];
	int          err_count;
	longint      cycle_count;
	bit          no_stall;

	contour_cell_segmenter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_MAX) begin
			$display("contour_cell_segmenter verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		err_count++;
	endtask

	// Works out every segment of one cell under the current register values.
	function automatic void predict_segments(input in_item_t c);
		logic signed [23:0] h[4];
		longint s[4], lv[4], px[4], py[4];
		longint lo, hi, k, kend, bp, cx, cy, n, d, off, pen;
		bit hit[4];
		bit ovf;
		int e, a, m, st, en;
		out_item_t r;
		out_item_t segs[$];
		h[0] = c.h_top_left;
		h[1] = c.h_top_right;
		h[2] = c.h_bottom_right;
		h[3] = c.h_bottom_left;
		bp = longint'(cfg_bp);
		cx = longint'(c.cell_x);
		cy = longint'(c.cell_y);
		lo = 0;
		hi = 0;
		// Scale, clamp and floor each corner.
		for (int i = 0; i < 4; i++) begin
			s[i] = longint'(h[i]) * longint'({40'd0, cfg_inv});
			if (s[i] < LEVEL_LO * FRAC_ONE) s[i] = LEVEL_LO * FRAC_ONE;
			if (s[i] > LEVEL_HI * FRAC_ONE) s[i] = LEVEL_HI * FRAC_ONE;
			if (s[i] >= 0) lv[i] = s[i] / FRAC_ONE;
			else lv[i] = -((-s[i] + FRAC_ONE - 1) / FRAC_ONE);
			if (i == 0 || lv[i] < lo) lo = lv[i];
			if (i == 0 || lv[i] > hi) hi = lv[i];
		end
		ovf = (hi - lo) > MAX_LVL;
		kend = ovf ? lo + MAX_LVL : hi;
		for (k = lo + 1; k <= kend; k++) begin
			pen = k % PENS;
			if (pen < 0) pen += PENS;
			// Crossing points on each edge.
			for (e = 0; e < 4; e++) begin
				a = (e + 3) & 3;
				off = 0;
				hit[e] = (lv[a] < k) != (lv[e] < k);
				if (hit[e]) begin
					d = s[e] - s[a];
					if (e == 1 || e == 2) n = k * FRAC_ONE - s[a];
					else n = s[e] - k * FRAC_ONE;
					if (d < 0) begin
						n = -n;
						d = -d;
					end
					if (n < 0) n = 0;
					if (d > 0) off = (bp * n) / d;
				end
				if (e & 1) begin
					px[e] = cx + off;
					py[e] = cy + (e == 3 ? bp : 0);
				end else begin
					px[e] = cx + (e == 2 ? bp : 0);
					py[e] = cy + off;
				end
			end
			// Pair crossed edges in edge order.
			e = 0;
			while (e < 4) begin
				if (!hit[e]) begin
					e++;
					continue;
				end
				m = e + 1;
				while (m < 4 && !hit[m]) m++;
				if (m >= 4) break;
				st = e;
				en = m;
				if (e == 2 && m == 3) begin
					st = 3;
					en = 2;
				end
				if (segs.size() < RESULT_LIMIT) begin
					r.x_start = px[st][16:0];
					r.y_start = py[st][16:0];
					r.x_end = px[en][16:0];
					r.y_end = py[en][16:0];
					r.pen_index = pen[2:0];
					r.level_overflow = ovf;
					r.last = 1'b0;
					segs.push_back(r);
				end
				e = m + 1;
			end
		end
		if (segs.size() > 0) segs[segs.size() - 1].last = 1'b1;
		foreach (segs[i]) seg_expect_q.push_back(segs[i]);
	endfunction

	// Compare each output transfer with the oldest expected segment.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (seg_expect_q.size() == 0) begin
				report_mismatch("unexpected segment, x_start", out_data.x_start, -1);
			end else begin
				want = seg_expect_q.pop_front();
				if (out_data.x_start !== want.x_start)
					report_mismatch("x_start", out_data.x_start, want.x_start);
				if (out_data.y_start !== want.y_start)
					report_mismatch("y_start", out_data.y_start, want.y_start);
				if (out_data.x_end !== want.x_end)
					report_mismatch("x_end", out_data.x_end, want.x_end);
				if (out_data.y_end !== want.y_end)
					report_mismatch("y_end", out_data.y_end, want.y_end);
				if (out_data.pen_index !== want.pen_index)
					report_mismatch("pen_index", out_data.pen_index, want.pen_index);
				if (out_data.level_overflow !== want.level_overflow)
					report_mismatch("level_overflow", out_data.level_overflow,
						want.level_overflow);
				if (out_data.last !== want.last)
					report_mismatch("last", out_data.last, want.last);
			end
		end
	end

	// Receiver: random stall before each segment, unless this phase runs without stalls.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 12);
			repeat (gap) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic apb_check_read(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report_mismatch("register readback", prdata, want);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Wait until every expected segment has arrived, then wait out IDLE_WAIT so the back end can go quiet.
	task automatic drain_segments();
		while (seg_expect_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_registers(input logic [23:0] inv, input logic [7:0] bp);
		drain_segments();
		apb_write(ADDR_INV_INTERVAL, {8'd0, inv});
		apb_write(ADDR_BLOCK_PIXELS, {24'd0, bp});
		cfg_inv = inv;
		cfg_bp = bp;
		apb_check_read(ADDR_INV_INTERVAL, {8'd0, inv});
		apb_check_read(ADDR_BLOCK_PIXELS, {24'd0, bp});
	endtask

	// Send one cell and record what it should produce once the transfer happens.
	task automatic send_cell(input in_item_t c, input row_kind_t kind, input out_item_t seg);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = c;
		do @(posedge clk); while (!in_ready);
		if (kind == ROW_PREDICT) predict_segments(c);
		else if (kind == ROW_ONE) seg_expect_q.push_back(seg);
	endtask

	function automatic in_item_t make_cell(input int a, input int b, input int c, input int d,
		input int x, input int y);
		in_item_t g;
		g.h_top_left = a[23:0];
		g.h_top_right = b[23:0];
		g.h_bottom_right = c[23:0];
		g.h_bottom_left = d[23:0];
		g.cell_x = x[15:0];
		g.cell_y = y[15:0];
		return g;
	endfunction

	task automatic add_row(input logic [23:0] inv, input logic [7:0] bp, input in_item_t g,
		input row_kind_t kind, input out_item_t seg);
		dir_row_t r;
		r.inv = inv;
		r.bp = bp;
		r.grid_item = g;
		r.kind = kind;
		r.seg = seg;
		dir_rows.push_back(r);
	endtask

	// Saturate to the signed 24-bit height range.
	function automatic logic [23:0] sat24(input longint v);
		if (v > 64'sd8388607) v = 64'sd8388607;
		if (v < -64'sd8388608) v = -64'sd8388608;
		return v[23:0];
	endfunction

	// Random cell: mostly a few levels around a base, some full range, some flat.
	function automatic in_item_t random_cell();
		in_item_t g;
		longint base, dh;
		int mode;
		mode = $urandom_range(0, 9);
		g.cell_x = $urandom;
		g.cell_y = $urandom;
		if (mode < 6) begin
			dh = (longint'($urandom_range(1, 5)) * FRAC_ONE) / longint'({40'd0, cfg_inv});
			if (dh > 64'sd4194304) dh = 64'sd4194304;
			base = longint'($signed(24'($urandom)));
			g.h_top_left = sat24(base + longint'($urandom_range(0, 32'(dh))));
			g.h_top_right = sat24(base + longint'($urandom_range(0, 32'(dh))));
			g.h_bottom_right = sat24(base + longint'($urandom_range(0, 32'(dh))));
			g.h_bottom_left = sat24(base + longint'($urandom_range(0, 32'(dh))));
		end else if (mode < 9) begin
			g.h_top_left = $urandom;
			g.h_top_right = $urandom;
			g.h_bottom_right = $urandom;
			g.h_bottom_left = $urandom;
		end else begin
			g.h_top_left = $urandom;
			g.h_top_right = g.h_top_left;
			g.h_bottom_right = g.h_top_left;
			g.h_bottom_left = g.h_top_left;
		end
		return g;
	endfunction

	// Main sequence.
	initial begin
		out_item_t seg;
		out_item_t blank;
		logic [23:0] inv;
		logic [7:0] bp;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		cycle_count = 0;
		no_stall = 1'b0;
		cfg_inv = INV_INTERVAL_RST;
		cfg_bp = BLOCK_PIXELS_RST;
		blank = '0;

		// Directed rows under several register settings.
		seg = '{x_start: 17'd8, y_start: 17'd0, x_end: 17'd8, y_end: 17'd8,
			pen_index: 3'd1, level_overflow: 1'b0, last: 1'b1};
		add_row(24'd65536, 8'd8, make_cell(0, 0, 0, 0, 0, 0), ROW_NONE, blank);
		add_row(24'd65536, 8'd8, make_cell(0, 256, 256, 0, 0, 0), ROW_ONE, seg);
		add_row(24'd65536, 8'd8, make_cell(8388607, 8388607, 8388607, 8388607, 65535, 65535),
			ROW_NONE, blank);
		add_row(24'd65536, 8'd8, make_cell(-8388608, -8388608, -8388608, -8388608, 0, 0),
			ROW_NONE, blank);
		add_row(24'd65536, 8'd8, make_cell(-8388608, 8388607, 8388607, 8388607, 100, 200),
			ROW_PREDICT, blank);
		add_row(24'd65536, 8'd8, make_cell(8388607, -8388608, 8388607, -8388608, 65535, 65535),
			ROW_PREDICT, blank);
		add_row(24'd65536, 8'd8, make_cell(-1000, -300, 500, 1200, 7, 9), ROW_PREDICT, blank);
		add_row(24'd65536, 8'd8, make_cell(1000, -900, 1100, -800, 40, 40), ROW_PREDICT, blank);
		add_row(24'd65536, 8'd8, make_cell(300, 300, 300, 1400, 1, 2), ROW_PREDICT, blank);
		add_row(24'd1, 8'd255, make_cell(8388607, -8388608, 0, 12345, 65535, 0), ROW_PREDICT,
			blank);
		add_row(24'd16777215, 8'd1, make_cell(100, -100, 50, -7, 0, 65535), ROW_PREDICT, blank);
		add_row(24'd16777215, 8'd1, make_cell(3, 0, -3, 1, 20, 30), ROW_PREDICT, blank);
		add_row(24'd0, 8'd8, make_cell(8388607, -8388608, 8388607, -8388608, 5, 5), ROW_NONE,
			blank);
		add_row(24'd65536, 8'd0, make_cell(0, 1024, -512, 300, 10, 10), ROW_PREDICT, blank);
		add_row(24'd65536, 8'd255, make_cell(0, 4096, 8192, 2048, 65535, 65535), ROW_PREDICT,
			blank);
		add_row(24'd65536, 8'd255, make_cell(-2560, 2560, -2560, 2560, 3, 3), ROW_PREDICT,
			blank);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].inv != cfg_inv || dir_rows[i].bp != cfg_bp) begin
				@(negedge clk);
				in_valid = 1'b0;
				set_registers(dir_rows[i].inv, dir_rows[i].bp);
			end
			send_cell(dir_rows[i].grid_item, dir_rows[i].kind, dir_rows[i].seg);
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					inv = 24'd65536;
					bp = 8'd8;
				end
				1: begin
					inv = 24'd1;
					bp = 8'd255;
				end
				2: begin
					inv = 24'd16777215;
					bp = 8'd1;
				end
				default: begin
					inv = $urandom_range(1, 16777215);
					bp = $urandom_range(1, 255);
				end
			endcase
			@(negedge clk);
			in_valid = 1'b0;
			set_registers(inv, bp);
			no_stall = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) send_cell(random_cell(), ROW_PREDICT, blank);
		end

		@(negedge clk);
		in_valid = 1'b0;
		drain_segments();
		if (err_count == 0) begin
			$display("contour_cell_segmenter verification clean");
		end else begin
			$display("contour_cell_segmenter verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ccs_pkg.sv
src/ccs_front.sv
src/ccs_queue.sv
src/ccs_back.sv
src/contour_cell_segmenter.sv
dv/tb_contour_cell_segmenter.sv
